### rtl/d2i_pkg.sv
// Shared types and constants for the double-to-integer conversion pipeline.
// Used by every stage module and by the top level; depends on nothing.
package d2i_pkg;

  localparam int unsigned ExpW  = 11;
  localparam int unsigned MantW = 53;
  localparam int unsigned IntW  = 64;
  localparam int unsigned ShW   = 6;

  localparam logic [ShW-1:0]  SHIFT_BASE = 6'h3E;
  localparam logic [ExpW-1:0] EXP_BIAS   = 11'h3FF;
  localparam logic [ExpW-1:0] LIMIT_S32  = 11'd1053;
  localparam logic [ExpW-1:0] LIMIT_U32  = 11'd1085;
  localparam logic [ExpW-1:0] LIMIT_S64  = 11'd1085;
  localparam logic [ExpW-1:0] LIMIT_U64  = 11'd1086;

  localparam logic [IntW-1:0] FILL_S32  = 64'hFFFF_FFFF_8000_0000;
  localparam logic [IntW-1:0] FILL_MSB  = 64'h8000_0000_0000_0000;
  localparam logic [IntW-1:0] MASK_LO32 = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic             neg;
    logic             sgn;
    logic             w32;
    logic             ovf;
    logic             unf;
    logic [ShW-1:0]   sh;
    logic [MantW-1:0] mant;
  } d2i_dec_t;

  typedef struct packed {
    logic            neg;
    logic            sgn;
    logic            w32;
    logic            ovf;
    logic            unf;
    logic [IntW-1:0] mag;
  } d2i_mag_t;

  typedef struct packed {
    logic [IntW-1:0] res;
    logic            ovf;
    logic            unf;
  } d2i_res_t;

endpackage

### rtl/d2i_decode.sv
// First stage: split the double, classify the exponent against the mode limit
// and form the shift amount. Depends on d2i_pkg.
module d2i_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_stall,
  input  logic [63:0]        operand_bits,
  input  logic               is_signed,
  input  logic               is_word32,
  output logic               dn_valid,
  input  logic               dn_stall,
  output d2i_pkg::d2i_dec_t  dn_data
);

  logic              valid_r;
  d2i_pkg::d2i_dec_t data_r;
  d2i_pkg::d2i_dec_t data_nxt;
  logic              adv;
  logic [10:0]       expo;
  logic [10:0]       limit;
  logic              neg;

  assign adv      = !valid_r || !dn_stall;
  assign up_stall = !adv;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    neg   = operand_bits[63];
    expo  = operand_bits[62:52];
    if (is_word32) begin
      limit = is_signed ? d2i_pkg::LIMIT_S32 : d2i_pkg::LIMIT_U32;
    end else begin
      limit = (is_signed || neg) ? d2i_pkg::LIMIT_S64 : d2i_pkg::LIMIT_U64;
    end
    data_nxt.neg  = neg;
    data_nxt.sgn  = is_signed;
    data_nxt.w32  = is_word32;
    data_nxt.ovf  = expo > limit;
    data_nxt.unf  = !(expo > limit) && (expo < d2i_pkg::EXP_BIAS);
    data_nxt.sh   = d2i_pkg::SHIFT_BASE - expo[5:0];
    data_nxt.mant = {(expo != 11'd0), operand_bits[51:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/d2i_shift.sv
// Second stage: align the mantissa at bit 63 and shift it right to the
// integer magnitude. Depends on d2i_pkg.
module d2i_shift (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_stall,
  input  d2i_pkg::d2i_dec_t  up_data,
  output logic               dn_valid,
  input  logic               dn_stall,
  output d2i_pkg::d2i_mag_t  dn_data
);

  logic              valid_r;
  d2i_pkg::d2i_mag_t data_r;
  d2i_pkg::d2i_mag_t data_nxt;
  logic              adv;
  logic [63:0]       aligned;

  assign adv      = !valid_r || !dn_stall;
  assign up_stall = !adv;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    aligned      = {up_data.mant, 11'b0};
    data_nxt.neg = up_data.neg;
    data_nxt.sgn = up_data.sgn;
    data_nxt.w32 = up_data.w32;
    data_nxt.ovf = up_data.ovf;
    data_nxt.unf = up_data.unf;
    if (up_data.ovf || up_data.unf) begin
      data_nxt.mag = '0;
    end else begin
      data_nxt.mag = aligned >> up_data.sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/d2i_fill.sv
// Third stage: negate the magnitude of a negative input and apply the upper-bit fill
// or mask of the mode; its register drives the result channel. Depends on d2i_pkg.
module d2i_fill (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_stall,
  input  d2i_pkg::d2i_mag_t  up_data,
  output logic               dn_valid,
  input  logic               dn_stall,
  output d2i_pkg::d2i_res_t  dn_data
);

  logic              valid_r;
  d2i_pkg::d2i_res_t data_r;
  d2i_pkg::d2i_res_t data_nxt;
  logic              adv;
  logic              res_neg;
  logic [63:0]       res;

  assign adv      = !valid_r || !dn_stall;
  assign up_stall = !adv;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    res_neg = (up_data.neg || up_data.ovf) && !up_data.unf;
    res     = up_data.neg ? (~up_data.mag + 64'd1) : up_data.mag;
    if (up_data.sgn) begin
      if (res_neg) begin
        res = res | (up_data.w32 ? d2i_pkg::FILL_S32 : d2i_pkg::FILL_MSB);
      end
    end else if (up_data.w32) begin
      res = res & d2i_pkg::MASK_LO32;
    end else if (up_data.ovf) begin
      res = res | d2i_pkg::FILL_MSB;
    end
    data_nxt.res = res;
    data_nxt.ovf = up_data.ovf;
    data_nxt.unf = up_data.unf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/double_to_integer_convert_unit.sv
// Top level of the double-to-integer conversion unit: decode, shift and fill
// stages in a row. Depends on d2i_pkg, d2i_decode, d2i_shift and d2i_fill.
//
// Usage:
//   Input channel: in_valid / in_stall with in_operand_bits (raw double),
//   in_is_signed and in_is_word32. A transaction is taken at a clock edge
//   where in_valid is high and in_stall is low.
//   Result channel: out_valid / out_stall with out_int_result,
//   out_overflow_flag and out_underflow_flag, one result per transaction,
//   in order.
//   Pipeline: three register stages (decode, mantissa shift, negate and
//   fill); out_valid rises once a transaction has passed all three, and the
//   result is taken at an edge where out_valid is high and out_stall is low.
//   Throughput: one transaction per cycle while out_stall is low.
//   Stall: a stalled result holds its payload; each stage advances whenever
//   the stage after it is empty or moving, so bubbles close up and up to
//   three transactions stay buffered before in_stall is raised.
//   Reset: rst_n low for one edge empties all stages; there is no other
//   state and no configuration.
module double_to_integer_convert_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_operand_bits,
  input  logic        in_is_signed,
  input  logic        in_is_word32,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_int_result,
  output logic        out_overflow_flag,
  output logic        out_underflow_flag
);

  logic              s1_valid;
  logic              s1_stall;
  d2i_pkg::d2i_dec_t s1_data;
  logic              s2_valid;
  logic              s2_stall;
  d2i_pkg::d2i_mag_t s2_data;
  d2i_pkg::d2i_res_t s3_data;

  d2i_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (in_valid),
    .up_stall     (in_stall),
    .operand_bits (in_operand_bits),
    .is_signed    (in_is_signed),
    .is_word32    (in_is_word32),
    .dn_valid     (s1_valid),
    .dn_stall     (s1_stall),
    .dn_data      (s1_data)
  );

  d2i_shift u_shift (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_stall (s1_stall),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_stall (s2_stall),
    .dn_data  (s2_data)
  );

  d2i_fill u_fill (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_stall (s2_stall),
    .up_data  (s2_data),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_data  (s3_data)
  );

  assign out_int_result     = s3_data.res;
  assign out_overflow_flag  = s3_data.ovf;
  assign out_underflow_flag = s3_data.unf;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_overflow_flag && out_underflow_flag))
    else $error("overflow and underflow raised together");

  a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_underflow_flag) |-> (out_int_result == 64'd0))
    else $error("underflow result not zero");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && s1_valid && s2_valid))
    else $error("input stalled with room in the pipeline");

  a_no_bubble_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && !out_valid) |=> out_valid)
    else $error("filled stage did not advance into empty output");

endmodule

### verif/d2i_result_checker.sv
// Result checker for double_to_integer_convert_unit: watches both channels,
// predicts each conversion and compares results in order. Depends on d2i_pkg.
module d2i_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] in_operand_bits,
  input  logic        in_is_signed,
  input  logic        in_is_word32,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_int_result,
  input  logic        out_overflow_flag,
  input  logic        out_underflow_flag,
  output int          mismatch_count,
  output int          expected_depth
);

  d2i_pkg::d2i_res_t expected_results[$];

  function automatic d2i_pkg::d2i_res_t convert_double(logic [63:0] bits, logic sgn,
                                                       logic w32);
    logic              neg;
    logic [10:0]       expo;
    logic [52:0]       mant;
    logic [10:0]       limit;
    logic              ovf;
    logic              unf;
    logic              res_neg;
    logic [5:0]        sh;
    logic [63:0]       mag;
    logic [63:0]       res;
    d2i_pkg::d2i_res_t r;
    neg  = bits[63];
    expo = bits[62:52];
    mant = {expo != 11'd0, bits[51:0]};
    if (w32) begin
      limit = sgn ? d2i_pkg::LIMIT_S32 : d2i_pkg::LIMIT_U32;
    end else begin
      limit = (sgn || neg) ? d2i_pkg::LIMIT_S64 : d2i_pkg::LIMIT_U64;
    end
    ovf = expo > limit;
    unf = 1'b0;
    mag = '0;
    if (!ovf) begin
      if (expo < d2i_pkg::EXP_BIAS) begin
        unf = 1'b1;
      end else begin
        sh  = d2i_pkg::SHIFT_BASE - expo[5:0];
        mag = {mant, 11'b0} >> sh;
      end
    end
    res_neg = (neg || ovf) && !unf;
    res = neg ? (~mag + 64'd1) : mag;
    if (sgn) begin
      if (res_neg) res = res | (w32 ? d2i_pkg::FILL_S32 : d2i_pkg::FILL_MSB);
    end else if (w32) begin
      res = res & d2i_pkg::MASK_LO32;
    end else if (ovf) begin
      res = res | d2i_pkg::FILL_MSB;
    end
    r.res = res;
    r.ovf = ovf;
    r.unf = unf;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 100) begin
      $display("mismatch in %s: got %h, expected %h", what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    d2i_pkg::d2i_res_t want;
    if (!rst_n) begin
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", out_int_result, 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_int_result !== want.res)
            report_mismatch("int_result", out_int_result, want.res);
          if (out_overflow_flag !== want.ovf)
            report_mismatch("overflow_flag", 64'(out_overflow_flag), 64'(want.ovf));
          if (out_underflow_flag !== want.unf)
            report_mismatch("underflow_flag", 64'(out_underflow_flag), 64'(want.unf));
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(convert_double(in_operand_bits, in_is_signed,
                                                  in_is_word32));
      end
    end
    expected_depth = expected_results.size();
  end

endmodule

### verif/tb_double_to_integer_convert_unit.sv
// Testbench top for double_to_integer_convert_unit: drives edge-case and random
// doubles in all four modes under varying idle and stall, and gives the verdict.
// Depends on d2i_pkg, the unit itself and d2i_result_checker.
module tb_double_to_integer_convert_unit;

  localparam int CycleLimit   = 200000;
  localparam int PhaseItems   = 212;
  localparam int SenderIdle[4] = '{0, 51, 0, 17};
  localparam int RecvStall[4]  = '{0, 0, 51, 17};
  localparam logic [63:0] EdgeOperands[12] = '{
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
    64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000, 64'h41DF_FFFF_FFC0_0000,
    64'h41E0_0000_0000_0000, 64'h43DF_FFFF_FFFF_FFFF, 64'h43E0_0000_0000_0000,
    64'hC3E0_0000_0000_0000, 64'h7FF8_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_operand_bits = '0;
  logic        in_is_signed = 1'b0;
  logic        in_is_word32 = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_int_result;
  logic        out_overflow_flag;
  logic        out_underflow_flag;
  int          mismatch_count;
  int          expected_depth;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          cycle_count = 0;

  always #5 clk = ~clk;

  double_to_integer_convert_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operand_bits    (in_operand_bits),
    .in_is_signed       (in_is_signed),
    .in_is_word32       (in_is_word32),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_int_result     (out_int_result),
    .out_overflow_flag  (out_overflow_flag),
    .out_underflow_flag (out_underflow_flag)
  );

  d2i_result_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operand_bits    (in_operand_bits),
    .in_is_signed       (in_is_signed),
    .in_is_word32       (in_is_word32),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_int_result     (out_int_result),
    .out_overflow_flag  (out_overflow_flag),
    .out_underflow_flag (out_underflow_flag),
    .mismatch_count     (mismatch_count),
    .expected_depth     (expected_depth)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_conversion(input logic [63:0] bits, input logic sgn,
                                 input logic w32);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_operand_bits <= bits;
    in_is_signed    <= sgn;
    in_is_word32    <= w32;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_depth != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] random_double();
    logic [63:0]  raw;
    logic [10:0]  expo;
    logic [51:0]  frac;
    int unsigned  pick;
    raw  = {$urandom, $urandom};
    frac = raw[51:0];
    pick = $urandom_range(99);
    if (pick < 45) begin
      expo = 11'd1023 + 11'($urandom_range(66));
    end else if (pick < 55) begin
      expo = d2i_pkg::LIMIT_S32 - 11'd2 + 11'($urandom_range(4));
    end else if (pick < 70) begin
      expo = 11'($urandom_range(1022));
    end else if (pick < 78) begin
      expo = 11'd0;
    end else if (pick < 84) begin
      expo = 11'h7FF;
    end else begin
      expo = 11'($urandom_range(2047));
    end
    pick = $urandom_range(9);
    if (pick == 0) frac = '0;
    else if (pick == 1) frac = '1;
    return {raw[63], expo, frac};
  endfunction

  initial begin
    logic [1:0] mode;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 12; i++) begin
      for (int k = 0; k < 2; k++) begin
        mode = 2'(i + k);
        send_conversion(EdgeOperands[i], mode[0], mode[1]);
      end
    end
    drain_results();

    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = SenderIdle[p];
      recv_stall_pct  = RecvStall[p];
      for (int n = 0; n < PhaseItems; n++) begin
        send_conversion(random_double(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      drain_results();
    end

    recv_stall_pct = 0;
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && expected_depth == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/d2i_pkg.sv
rtl/d2i_decode.sv
rtl/d2i_shift.sv
rtl/d2i_fill.sv
rtl/double_to_integer_convert_unit.sv
verif/d2i_result_checker.sv
verif/tb_double_to_integer_convert_unit.sv
